/* hdl/bpt_pkg.sv */
package bpt_pkg;

  localparam int WORD_LINES  = 512;
  localparam int SLICE_WIDTH = 64;

  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 18;
  localparam int PLANES   = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam int BEATS_RAW = (SLICE_WIDTH + 7) / 8;
  localparam int BEATS     = (BEATS_RAW > 8) ? 8 : ((BEATS_RAW < 1) ? 1 : BEATS_RAW);
  localparam int ROW_BITS  = BEATS * 8;
  localparam int ROW_MAX   = 512;

  localparam logic [DATA_W-1:0] SLICE_MASK =
    (SLICE_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : ((64'd1 << SLICE_WIDTH) - 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ARRAY  = 8'd0,
    REG_ROW_COUNT   = 8'd1,
    REG_TOP_BIT     = 8'd2,
    REG_BUFFER_MODE = 8'd3
  } cfg_reg_t;

  // subarray offset per plane, indexed by buffer mode
  localparam logic [4:0] PLANE_OFFSET [4][PLANES] = '{
    '{5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd0, 5'd1, 5'd2,  5'd4,  5'd5,  5'd6,  5'd8,  5'd9},
    '{5'd0, 5'd1, 5'd4,  5'd5,  5'd8,  5'd9,  5'd12, 5'd13},
    '{5'd0, 5'd4, 5'd8,  5'd12, 5'd16, 5'd20, 5'd24, 5'd28}
  };

endpackage

/* hdl/bpt_in_if.sv */
interface bpt_in_if;
  import bpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

/* hdl/bpt_out_if.sv */
interface bpt_out_if;
  import bpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] array_address;
  logic [DATA_W-1:0] bit_slice;
  logic [2:0]        plane_index;
  logic              row_last;
  logic              job_done;
  modport source (output valid, output array_address, output bit_slice,
                  output plane_index, output row_last, output job_done, input ready);
  modport sink   (input valid, input array_address, input bit_slice,
                  input plane_index, input row_last, input job_done, output ready);
endinterface

/* hdl/bpt_cfg_if.sv */
interface bpt_cfg_if;
  import bpt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/bit_plane_transposer_core.sv */
// Channel   Dir  Word                                         Taken when
// cfg       in   index, data (register write)                 cfg.valid & cfg.ready
// data_in   in   data_word, eight row bytes little-endian     data_in.valid & data_in.ready
// data_out  out  array_address, bit_slice, plane_index,       data_out.valid & data_out.ready
//                row_last, job_done
//
// A row takes BEATS input words, one a cycle while data_in is not stalled,
// each shifting one byte of every bit plane into the gather bank. The finished
// row moves to the emit bank, which gives one plane a cycle while data_out is
// ready, planes 0 to top_bit. Gathering of the next row overlaps emission; only
// the row's final word waits while the emit bank still drains. Config is always ready.
// Reset (rst, synchronous) clears counters, flags and config registers; the banks
// hold no reset value and need no clearing pass.
module bit_plane_transposer_core (
  input logic clk,
  input logic rst,
  bpt_cfg_if.sink   cfg,
  bpt_in_if.sink    data_in,
  bpt_out_if.source data_out
);
  import bpt_pkg::*;

  // configuration
  logic [7:0] base_array;
  logic [9:0] row_count;
  logic [2:0] top_bit;
  logic [1:0] buffer_mode;

  // gather side
  logic [2:0]          beat_count;
  logic [8:0]          row_index;
  logic [ROW_BITS-1:0] gplane      [PLANES];
  logic [ROW_BITS-1:0] gplane_next [PLANES];
  logic [7:0]          byte_bits   [PLANES];

  // emit side
  logic                busy;
  logic [2:0]          pcnt;
  logic [8:0]          emit_row;
  logic                emit_last_row;
  logic [ROW_BITS-1:0] bank [PLANES];

  logic       final_beat, in_acc, load, out_acc, is_last, last_row;
  logic [9:0] rows;
  logic [8:0] array_id;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_array  <= 8'd0;
      row_count   <= 10'd512;
      top_bit     <= 3'd7;
      buffer_mode <= 2'd3;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BASE_ARRAY:  base_array  <= cfg.data[7:0];
        REG_ROW_COUNT:   row_count   <= cfg.data[9:0];
        REG_TOP_BIT:     top_bit     <= cfg.data[2:0];
        REG_BUFFER_MODE: buffer_mode <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // rows per job: zero reads as one, saturate at counter reach
  always_comb begin
    if (row_count == 10'd0) rows = 10'd1;
    else if (row_count > 10'(ROW_MAX)) rows = 10'(ROW_MAX);
    else rows = row_count;
  end
  assign last_row = ({1'b0, row_index} + 10'd1) >= rows;

  assign final_beat    = (beat_count == 3'(BEATS - 1));
  assign data_in.ready = !(busy && final_beat);
  assign in_acc        = data_in.valid && data_in.ready;
  assign load          = in_acc && final_beat;

  // one byte of each plane per word: new bits enter at the top
  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      for (int k = 0; k < 8; k++) byte_bits[p][k] = data_in.data_word[8*k + p];
      gplane_next[p] = (gplane[p] >> 8) | (ROW_BITS'(byte_bits[p]) << (ROW_BITS - 8));
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int p = 0; p < PLANES; p++) gplane[p] <= gplane_next[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_count <= 3'd0;
      row_index  <= 9'd0;
    end else if (in_acc) begin
      if (final_beat) begin
        beat_count <= 3'd0;
        row_index  <= last_row ? 9'd0 : row_index + 9'd1;
      end else begin
        beat_count <= beat_count + 3'd1;
      end
    end
  end

  assign is_last = (pcnt == top_bit);
  assign out_acc = busy && data_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pcnt <= 3'd0;
    end else if (load) begin
      busy <= 1'b1;
      pcnt <= 3'd0;
    end else if (out_acc) begin
      if (is_last) busy <= 1'b0;
      else pcnt <= pcnt + 3'd1;
    end
  end

  // emit bank: plane 0 at the head, shifted down one plane per word
  always_ff @(posedge clk) begin
    if (load) begin
      for (int p = 0; p < PLANES; p++) bank[p] <= gplane_next[p];
      emit_row      <= row_index;
      emit_last_row <= last_row;
    end else if (out_acc) begin
      for (int p = 0; p < PLANES - 1; p++) bank[p] <= bank[p+1];
    end
  end

  assign array_id = 9'(base_array) + 9'(PLANE_OFFSET[buffer_mode][pcnt]);

  assign data_out.valid         = busy;
  assign data_out.array_address = ADDR_W'(32'(array_id) * WORD_LINES + 32'(emit_row));
  assign data_out.bit_slice     = DATA_W'(bank[0]) & SLICE_MASK;
  assign data_out.plane_index   = pcnt;
  assign data_out.row_last      = is_last;
  assign data_out.job_done      = is_last && emit_last_row;

`ifndef SYNTHESIS
  a_stall_only_busy: assert property (@(posedge clk) disable iff (rst)
    !data_in.ready |-> busy)
    else $error("input stalled with emit bank empty");

  a_done_on_row_last: assert property (@(posedge clk) disable iff (rst)
    data_out.valid && data_out.job_done |-> data_out.row_last)
    else $error("job_done without row_last");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    data_out.valid && data_out.ready && data_out.row_last |=> !data_out.valid)
    else $error("emit bank still busy after last plane");

  a_plane_step: assert property (@(posedge clk) disable iff (rst)
    data_out.valid && data_out.ready && !data_out.row_last |=>
      data_out.valid && (data_out.plane_index == 3'($past(data_out.plane_index) + 3'd1)))
    else $error("plane index did not advance");
`endif

endmodule
